// ----- sv/pi_controller_clamped_top_defines.svh -----
// Assertion macros for the PI controller with clamped integrator
`ifndef PI_CONTROLLER_CLAMPED_TOP_DEFINES_SVH
`define PI_CONTROLLER_CLAMPED_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PIC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PIC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PIC_ASSERT_IMP(label, ante, cons, msg)
`define PIC_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ----- sv/pic_pkg.sv -----
// Types and constants shared by the PI controller modules
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

	localparam int unsigned CFG_DATA_W = 31;

	localparam logic [1:0] REG_PROP_GAIN      = 2'd0;
	localparam logic [1:0] REG_INTEG_GAIN     = 2'd1;
	localparam logic [1:0] REG_INTEGRAL_LIMIT = 2'd2;
	localparam logic [1:0] REG_OUTPUT_LIMIT   = 2'd3;

	typedef logic signed [15:0] gain_t;
	typedef logic signed [15:0] sample_t;
	typedef logic signed [31:0] integ_t;

	typedef struct packed {
		gain_t       prop_gain;
		gain_t       integ_gain;
		logic [30:0] integral_limit;
		logic [14:0] output_limit;
	} cfg_t;

	localparam gain_t       RST_PROP_GAIN      = 16'sd256;
	localparam gain_t       RST_INTEG_GAIN     = 16'sd0;
	localparam logic [30:0] RST_INTEGRAL_LIMIT = 31'd1638;
	localparam logic [14:0] RST_OUTPUT_LIMIT   = 15'd19660;

endpackage

`default_nettype wire

// ----- sv/pi_controller_clamped_top.sv -----
// PI controller with clamped integrator and clamped output: top level
// Throughput: one request per cycle while the output register is free; the integrator add and clamp is combinational.
// The three-stage pipeline advances as a whole whenever the output register is free.
// Reset (arst_n low, asynchronous) empties the pipeline, zeroes the integrator
// and loads the gain and limit registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "pi_controller_clamped_top_defines.svh"

module pi_controller_clamped_top import pic_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire sample_t               error_sample,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output sample_t                    drive_value,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t               cfg;
	logic               adv;
	logic               v_s1;
	logic               v_s2;
	sample_t            err_s1;
	integ_t             integral_q;
	logic signed [31:0] pprod_s2;
	logic signed [47:0] iprod_s2;
	logic signed [32:0] integ_ext;
	logic signed [32:0] ilim_ext;
	logic signed [32:0] ilim_neg;

	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	pic_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	pic_integ u_integ (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.in_valid       (in_valid),
		.error_sample   (error_sample),
		.integral_limit (cfg.integral_limit),
		.v_s1           (v_s1),
		.err_s1         (err_s1),
		.integral_q     (integral_q)
	);

	pic_mult u_mult (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.v_s1       (v_s1),
		.err_s1     (err_s1),
		.integral_q (integral_q),
		.prop_gain  (cfg.prop_gain),
		.integ_gain (cfg.integ_gain),
		.v_s2       (v_s2),
		.pprod_s2   (pprod_s2),
		.iprod_s2   (iprod_s2)
	);

	pic_outclamp u_outclamp (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.v_s2         (v_s2),
		.pprod_s2     (pprod_s2),
		.iprod_s2     (iprod_s2),
		.output_limit (cfg.output_limit),
		.out_valid    (out_valid),
		.drive_value  (drive_value)
	);

	assign integ_ext = 33'(integral_q);
	assign ilim_ext  = signed'({2'b00, cfg.integral_limit});
	assign ilim_neg  = -ilim_ext;

	`PIC_ASSERT_NXT(a_integ_bound, in_valid && !in_stall, (integ_ext <= $past(ilim_ext)) && (integ_ext >= $past(ilim_neg)), "integrator outside its limit")
	`PIC_ASSERT_IMP(a_out_from_s2, $rose(out_valid), $past(v_s2), "result without a request in flight")
	`PIC_ASSERT_NXT(a_s2_advance, v_s2 && !in_stall, out_valid, "request lost between product and output stage")

endmodule

`default_nettype wire

// ----- sv/pic_cfg.sv -----
// Configuration register file for gains and limits
`timescale 1ns / 1ps
`default_nettype none

module pic_cfg import pic_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [1:0]            wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= RST_PROP_GAIN;
			cfg_q.integ_gain     <= RST_INTEG_GAIN;
			cfg_q.integral_limit <= RST_INTEGRAL_LIMIT;
			cfg_q.output_limit   <= RST_OUTPUT_LIMIT;
		end else if (wr_en) begin
			case (wr_index)
				REG_PROP_GAIN:      cfg_q.prop_gain      <= signed'(wr_data[15:0]);
				REG_INTEG_GAIN:     cfg_q.integ_gain     <= signed'(wr_data[15:0]);
				REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= wr_data[30:0];
				REG_OUTPUT_LIMIT:   cfg_q.output_limit   <= wr_data[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- sv/pic_integ.sv -----
// Integrator stage: add the error sample and clamp the accumulator
`timescale 1ns / 1ps
`default_nettype none

module pic_integ import pic_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic        in_valid,
	input  wire sample_t     error_sample,
	input  wire logic [30:0] integral_limit,
	output logic             v_s1,
	output sample_t          err_s1,
	output integ_t           integral_q
);

	logic signed [32:0] sum_w;
	logic signed [32:0] lim_w;
	logic signed [32:0] neg_lim_w;
	logic signed [32:0] clamp_w;
	logic               accept;

	assign accept    = in_valid && adv;
	assign sum_w     = 33'(integral_q) + 33'(error_sample);
	assign lim_w     = signed'({2'b00, integral_limit});
	assign neg_lim_w = -lim_w;

	always_comb begin
		if (sum_w > lim_w) begin
			clamp_w = lim_w;
		end else if (sum_w < neg_lim_w) begin
			clamp_w = neg_lim_w;
		end else begin
			clamp_w = sum_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			integral_q <= '0;
		end else if (adv) begin
			v_s1 <= in_valid;
			if (accept) begin
				integral_q <= signed'(clamp_w[31:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1 <= error_sample;
		end
	end

endmodule

`default_nettype wire

// ----- sv/pic_mult.sv -----
// Product stage: proportional and integral products
`timescale 1ns / 1ps
`default_nettype none

module pic_mult import pic_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          v_s1,
	input  wire sample_t       err_s1,
	input  wire integ_t        integral_q,
	input  wire gain_t         prop_gain,
	input  wire gain_t         integ_gain,
	output logic               v_s2,
	output logic signed [31:0] pprod_s2,
	output logic signed [47:0] iprod_s2
);

	logic signed [31:0] pprod_w;
	logic signed [47:0] iprod_w;

	assign pprod_w = 32'(prop_gain) * 32'(err_s1);
	assign iprod_w = 48'(integ_gain) * 48'(integral_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			pprod_s2 <= pprod_w;
			iprod_s2 <= iprod_w;
		end
	end

endmodule

`default_nettype wire

// ----- sv/pic_outclamp.sv -----
// Output stage: sum, divide by 256 and clamp to the output limit
`timescale 1ns / 1ps
`default_nettype none

module pic_outclamp import pic_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          v_s2,
	input  wire logic signed [31:0] pprod_s2,
	input  wire logic signed [47:0] iprod_s2,
	input  wire logic [14:0]   output_limit,
	output logic               out_valid,
	output sample_t            drive_value
);

	logic signed [48:0] sum_w;
	logic signed [40:0] scaled_w;
	logic signed [40:0] lim_w;
	logic signed [40:0] neg_lim_w;
	logic signed [40:0] clamp_w;

	assign sum_w     = 49'(pprod_s2) + 49'(iprod_s2);
	assign scaled_w  = signed'(sum_w[48:8]);
	assign lim_w     = signed'({26'd0, output_limit});
	assign neg_lim_w = -lim_w;

	always_comb begin
		if (scaled_w > lim_w) begin
			clamp_w = lim_w;
		end else if (scaled_w < neg_lim_w) begin
			clamp_w = neg_lim_w;
		end else begin
			clamp_w = scaled_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			drive_value <= signed'(clamp_w[15:0]);
		end
	end

endmodule

`default_nettype wire

// ----- tb/pi_controller_clamped_top_tb.sv -----
// Testbench for the PI controller: directed table and random phases against a predictor
`timescale 1ns / 1ps

module pi_controller_clamped_top_tb;
	import pic_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int N_PHASES    = 10;
	localparam int PHASE_LEN   = 75;
	localparam int N_DIR       = 38;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  idx;
		logic [30:0] data;
		sample_t     sample;
		bit          known;
		sample_t     want;
	} row_t;

	typedef struct {
		bit      known;
		sample_t want;
	} typed_want_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	sample_t               error_sample = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	sample_t               drive_value;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [1:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	gain_t       kp_r   = RST_PROP_GAIN;
	gain_t       ki_r   = RST_INTEG_GAIN;
	logic [30:0] ilim_r = RST_INTEGRAL_LIMIT;
	logic [14:0] olim_r = RST_OUTPUT_LIMIT;
	integ_t      isum_r = '0;

	sample_t     drive_q [$];
	typed_want_t typed_q [$];
	typed_want_t tw;
	sample_t     predicted;
	sample_t     oldest;

	int  n_errors  = 0;
	int  n_sent    = 0;
	int  n_checked = 0;
	int  n_writes  = 0;
	int  n_known   = 0;
	bit  hold_off_req = 1'b0;
	bit  in_burst  = 1'b0;
	bit  out_burst = 1'b0;
	int  bias      = 0;

	row_t dir_rows [0:N_DIR-1] = '{
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, 0, 1'b1, 0},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, 100, 1'b1, 100},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, -1, 1'b1, -1},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, 32767, 1'b1, 19660},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, -32768, 1'b1, -19660},
		'{ROW_WRITE, REG_OUTPUT_LIMIT, 31'd0, 0, 1'b0, 0},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, 1000, 1'b1, 0},
		'{ROW_WRITE, REG_OUTPUT_LIMIT, 31'h7FFF, 0, 1'b0, 0},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, 32767, 1'b1, 32767},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, -32768, 1'b1, -32767},
		'{ROW_WRITE, REG_PROP_GAIN, 31'h8000, 0, 1'b0, 0},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, -32768, 1'b1, 32767},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, 32767, 1'b1, -32767},
		'{ROW_WRITE, REG_PROP_GAIN, 31'h7FFF, 0, 1'b0, 0},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, -32768, 1'b1, -32767},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, 12345, 1'b0, 0},
		'{ROW_WRITE, REG_PROP_GAIN, 31'd0, 0, 1'b0, 0},
		'{ROW_WRITE, REG_INTEG_GAIN, 31'd256, 0, 1'b0, 0},
		'{ROW_WRITE, REG_INTEGRAL_LIMIT, 31'd0, 0, 1'b0, 0},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, 500, 1'b1, 0},
		'{ROW_WRITE, REG_INTEGRAL_LIMIT, 31'd1000, 0, 1'b0, 0},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, 800, 1'b1, 800},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, 800, 1'b1, 1000},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, -3000, 1'b1, -1000},
		'{ROW_WRITE, REG_INTEGRAL_LIMIT, 31'd200, 0, 1'b0, 0},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, 0, 1'b1, -200},
		'{ROW_WRITE, REG_INTEGRAL_LIMIT, 31'h7FFFFFFF, 0, 1'b0, 0},
		'{ROW_WRITE, REG_INTEG_GAIN, 31'h7FFF, 0, 1'b0, 0},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, 32767, 1'b0, 0},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, 32767, 1'b0, 0},
		'{ROW_WRITE, REG_INTEG_GAIN, 31'h8000, 0, 1'b0, 0},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, -32768, 1'b0, 0},
		'{ROW_WRITE, REG_PROP_GAIN, 31'h7FFFFED4, 0, 1'b0, 0},
		'{ROW_WRITE, REG_INTEG_GAIN, 31'h5555000C, 0, 1'b0, 0},
		'{ROW_WRITE, REG_OUTPUT_LIMIT, 31'h7FFF0FFF, 0, 1'b0, 0},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, 4321, 1'b0, 0},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, -4321, 1'b0, 0},
		'{ROW_SAMPLE, REG_PROP_GAIN, 31'd0, 21845, 1'b0, 0}
	};

	pi_controller_clamped_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.error_sample (error_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive_value  (drive_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic sample_t next_drive(sample_t err);
		longint acc;
		longint lim;
		longint sum;
		longint q;
		longint olim;
		lim = longint'(ilim_r);
		acc = longint'(isum_r) + longint'(err);
		if (acc > lim) acc = lim;
		else if (acc < -lim) acc = -lim;
		isum_r = integ_t'(acc);
		sum = longint'(kp_r) * longint'(err) + longint'(ki_r) * acc;
		q = sum >>> 8;
		olim = longint'(olim_r);
		if (q > olim) q = olim;
		else if (q < -olim) q = -olim;
		return sample_t'(q);
	endfunction

	task automatic report_mismatch(string what, sample_t got, sample_t want);
		if (n_errors < 40)
			$display("mismatch at %0t: %s, got %0d, want %0d", $realtime, what, got, want);
		n_errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_checked++;
				if (drive_q.size() == 0) begin
					report_mismatch("drive_value with no request pending", drive_value, '0);
				end else begin
					oldest = drive_q.pop_front();
					if (drive_value !== oldest)
						report_mismatch("drive_value", drive_value, oldest);
				end
			end
			if (in_valid && !in_stall) begin
				tw = typed_q.pop_front();
				predicted = next_drive(error_sample);
				drive_q.push_back(tw.known ? tw.want : predicted);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PROP_GAIN:      kp_r = gain_t'(cfg_data[15:0]);
					REG_INTEG_GAIN:     ki_r = gain_t'(cfg_data[15:0]);
					REG_INTEGRAL_LIMIT: ilim_r = cfg_data[30:0];
					REG_OUTPUT_LIMIT:   olim_r = cfg_data[14:0];
					default: ;
				endcase
			end
		end
	end

	task automatic send_request(sample_t s, bit known, sample_t want);
		int gap;
		if ($urandom_range(31) == 0) in_burst = !in_burst;
		gap = in_burst ? 0 : $urandom_range(9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		typed_q.push_back('{known, want});
		in_valid     <= 1'b1;
		error_sample <= s;
		do @(posedge clk); while (in_stall);
		n_sent++;
		if (known) n_known++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (drive_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [30:0] val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_writes++;
	endtask

	function automatic gain_t pick_gain();
		case ($urandom_range(5))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2, 3:    return gain_t'($urandom_range(1024)) - 16'sd512;
			default: return gain_t'($urandom);
		endcase
	endfunction

	function automatic sample_t pick_sample();
		int v;
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(3))
					0:       v = 32767;
					1:       v = -32768;
					2:       v = 0;
					default: v = -1;
				endcase
			end
			1, 2:    v = int'(sample_t'($urandom));
			default: v = int'($urandom_range(1000)) - 500 + bias;
		endcase
		return sample_t'(v);
	endfunction

	initial begin
		gain_t       kp;
		gain_t       ki;
		logic [30:0] il;
		logic [14:0] ol;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIR; r++) begin
			if (dir_rows[r].kind == ROW_WRITE)
				write_reg(dir_rows[r].idx, dir_rows[r].data);
			else
				send_request(dir_rows[r].sample, dir_rows[r].known, dir_rows[r].want);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			kp = pick_gain();
			ki = pick_gain();
			case ($urandom_range(3))
				0:       il = '0;
				1:       il = 31'h7FFFFFFF;
				2:       il = 31'($urandom_range(4000));
				default: il = 31'($urandom);
			endcase
			case ($urandom_range(3))
				0:       ol = '0;
				1:       ol = 15'h7FFF;
				2:       ol = 15'($urandom_range(2000));
				default: ol = 15'($urandom);
			endcase
			if (p == N_PHASES - 1) begin
				il = 31'h7FFFFFFF;
				ol = 15'h7FFF;
			end
			write_reg(REG_PROP_GAIN, {15'($urandom), kp});
			write_reg(REG_INTEG_GAIN, {15'($urandom), ki});
			write_reg(REG_INTEGRAL_LIMIT, il);
			write_reg(REG_OUTPUT_LIMIT, {16'($urandom), ol});
			bias = $urandom_range(1) ? int'($urandom_range(2000)) : -int'($urandom_range(2000));
			if (p == 2) hold_off_req = 1'b1;
			for (int k = 0; k < PHASE_LEN; k++)
				send_request(pick_sample(), 1'b0, '0);
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (drive_q.size() != 0) begin
			$display("%0d results never arrived", drive_q.size());
			n_errors += drive_q.size();
		end
		$display("sent %0d error samples (%0d with typed results), checked %0d drive values",
			n_sent, n_known, n_checked);
		$display("%0d register writes over %0d random settings, one long output hold-off",
			n_writes, N_PHASES);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		int gap;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if ($urandom_range(31) == 0) out_burst = !out_burst;
				gap = out_burst ? 0 : $urandom_range(9);
				if (gap != 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
		$display("FAIL");
		$finish;
	end

endmodule
